/* hdl/rtp_handover_renumberer_top_assert.svh */
// Assertion macros shared by the RTP handover renumberer RTL.
`ifndef RTP_HANDOVER_RENUMBERER_TOP_ASSERT_SVH
`define RTP_HANDOVER_RENUMBERER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RHR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RHR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rhr_pkg.sv */
// Shared widths, register map and helper functions for the RTP handover renumberer.
package rhr_pkg;

    // Field widths.
    localparam int SRC_W  = 8;
    localparam int SEQ_W  = 16;
    localparam int TS_W   = 32;
    localparam int RWD_W  = 31;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register reset values.
    localparam logic [SEQ_W-1:0] MAX_SEQ_JUMP_RST   = 16'd3000;
    localparam logic [RWD_W-1:0] MAX_TS_REWIND_RST  = 31'd90000;
    localparam logic [TS_W-1:0]  HANDOVER_TICKS_RST = 32'd3000;

    // Register indexes (byte address is four times the index).
    typedef enum logic [1:0] {
        REG_MAX_SEQ_JUMP   = 2'd0,
        REG_MAX_TS_REWIND  = 2'd1,
        REG_HANDOVER_TICKS = 2'd2
    } t_reg_idx;

    // True when x is strictly ahead of y in 16-bit serial number arithmetic.
    function automatic logic seq_ahead(input logic [SEQ_W-1:0] x, input logic [SEQ_W-1:0] y);
        logic [SEQ_W-1:0] g;
        g = x - y;
        return (g != '0) && !g[SEQ_W-1];
    endfunction

endpackage

/* hdl/rhr_if.sv */
// Valid/ready channel interfaces for packet headers in and rewritten headers out.
interface rhr_in_if;
    import rhr_pkg::*;

    logic             valid;
    logic             ready;
    logic [SRC_W-1:0] source_id;
    logic [SEQ_W-1:0] in_sequence;
    logic [TS_W-1:0]  in_timestamp;

    modport source(output valid, source_id, in_sequence, in_timestamp, input ready);
    modport sink(input valid, source_id, in_sequence, in_timestamp, output ready);
endinterface

interface rhr_out_if;
    import rhr_pkg::*;

    logic             valid;
    logic             ready;
    logic [SEQ_W-1:0] seq_out;
    logic [TS_W-1:0]  ts_out;
    logic             rebased;

    modport source(output valid, seq_out, ts_out, rebased, input ready);
    modport sink(input valid, seq_out, ts_out, rebased, output ready);
endinterface

/* hdl/rtp_handover_renumberer_top.sv */
// RTP handover renumberer: rewrites sequence numbers and timestamps across source changes.
//
// Packet headers (source id, sequence, timestamp) arrive on i_in and rewritten headers
// leave on o_out; both are valid/ready channels and a transaction moves one header.
// Exactly one result follows each input transaction, in order.
// A header taken on i_in is captured in the input register, processed, and presented
// from the output register when it moves on from the input register.
// Throughput: one header per cycle while the receiver does not stall; the series state
// (offsets, high-water marks) is read and updated as a header passes from input to output register.
// When the receiver stalls, the output register holds its result and the input register
// keeps one more header; i_in.ready drops only when both are full and o_out.ready is low.
// Reset (i_rst_n low, synchronous) empties both registers, clears the series state so the
// next header passes through unchanged, and restores the register defaults.
// The APB port holds three registers: max sequence jump at 0x0, max timestamp rewind at
// 0x4 and handover ticks at 0x8. Writes complete in the access cycle; pready is always high.
// Registers should only be written while no transaction is in flight.
`include "rtp_handover_renumberer_top_assert.svh"

module rtp_handover_renumberer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rhr_in_if.sink                            i_in,
    rhr_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rhr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rhr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rhr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import rhr_pkg::*;

    // Configuration registers.
    logic [SEQ_W-1:0] r_max_seq_jump;
    logic [RWD_W-1:0] r_max_ts_rewind;
    logic [TS_W-1:0]  r_handover_ticks;

    // Input register.
    logic             r_in_valid;
    logic [SRC_W-1:0] r_in_source;
    logic [SEQ_W-1:0] r_in_seq;
    logic [TS_W-1:0]  r_in_ts;

    // Series state.
    logic             r_started;
    logic [SRC_W-1:0] r_cur_source;
    logic [SEQ_W-1:0] r_seq_off;
    logic [TS_W-1:0]  r_ts_off;
    logic [SEQ_W-1:0] r_last_in_seq;
    logic [TS_W-1:0]  r_last_in_ts;
    logic [SEQ_W-1:0] r_last_out_seq;
    logic [TS_W-1:0]  r_last_out_ts;

    // Output register.
    logic             r_out_valid;
    logic [SEQ_W-1:0] r_out_seq;
    logic [TS_W-1:0]  r_out_ts;
    logic             r_out_rebased;

    // Datapath signals.
    t_reg_idx         w_reg_idx;
    logic             w_cfg_wr;
    logic             w_adv;
    logic [SEQ_W-1:0] w_seq_diff;
    logic [SEQ_W:0]   w_seq_gap;
    logic [TS_W-1:0]  w_ts_diff;
    logic [TS_W:0]    w_ts_back;
    logic             w_rewound;
    logic             w_fresh;
    logic [SEQ_W-1:0] w_seq_next;
    logic [TS_W-1:0]  w_ts_handover;
    logic [SEQ_W-1:0] n_out_seq;
    logic [TS_W-1:0]  n_out_ts;
    logic             w_upd_out;
    logic             w_upd_in;

    // APB register access.
    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (w_reg_idx)
            REG_MAX_SEQ_JUMP:   prdata = {{(APB_DATA_W-SEQ_W){1'b0}}, r_max_seq_jump};
            REG_MAX_TS_REWIND:  prdata = {{(APB_DATA_W-RWD_W){1'b0}}, r_max_ts_rewind};
            REG_HANDOVER_TICKS: prdata = r_handover_ticks;
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_seq_jump   <= MAX_SEQ_JUMP_RST;
            r_max_ts_rewind  <= MAX_TS_REWIND_RST;
            r_handover_ticks <= HANDOVER_TICKS_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_MAX_SEQ_JUMP:   r_max_seq_jump   <= pwdata[SEQ_W-1:0];
                REG_MAX_TS_REWIND:  r_max_ts_rewind  <= pwdata[RWD_W-1:0];
                REG_HANDOVER_TICKS: r_handover_ticks <= pwdata[TS_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow: the held header moves on when the output register is free or taken.
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    // Sequence gap as the absolute signed 16-bit difference to the highest input seen.
    assign w_seq_diff = r_in_seq - r_last_in_seq;
    assign w_seq_gap  = w_seq_diff[SEQ_W-1] ? ((SEQ_W+1)'(1 << SEQ_W) - {1'b0, w_seq_diff})
                                            : {1'b0, w_seq_diff};

    // Timestamp rewind: a negative step whose magnitude exceeds the threshold.
    assign w_ts_diff = r_in_ts - r_last_in_ts;
    assign w_ts_back = (TS_W+1)'(64'd1 << TS_W) - {1'b0, w_ts_diff};
    assign w_rewound = w_ts_diff[TS_W-1] && (w_ts_back > {2'b00, r_max_ts_rewind});

    assign w_fresh = r_started && ((r_in_source != r_cur_source) ||
                     (w_seq_gap > {1'b0, r_max_seq_jump}) || w_rewound);

    // Continuation point for a new series.
    assign w_seq_next    = r_last_out_seq + SEQ_W'(1);
    assign w_ts_handover = r_last_out_ts + r_handover_ticks;

    // Rewritten header.
    always_comb begin
        if (!r_started) begin
            n_out_seq = r_in_seq;
            n_out_ts  = r_in_ts;
        end else if (w_fresh) begin
            n_out_seq = w_seq_next;
            n_out_ts  = w_ts_handover;
        end else begin
            n_out_seq = r_in_seq + r_seq_off;
            n_out_ts  = r_in_ts + r_ts_off;
        end
    end

    // High-water marks only move forward, except when a series begins.
    assign w_upd_out = !r_started || w_fresh || seq_ahead(n_out_seq, r_last_out_seq);
    assign w_upd_in  = !r_started || w_fresh || seq_ahead(r_in_seq, r_last_in_seq);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_source <= i_in.source_id;
            r_in_seq    <= i_in.in_sequence;
            r_in_ts     <= i_in.in_timestamp;
        end
    end

    // Series state update, once per header leaving the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started      <= 1'b0;
            r_cur_source   <= '0;
            r_seq_off      <= '0;
            r_ts_off       <= '0;
            r_last_in_seq  <= '0;
            r_last_in_ts   <= '0;
            r_last_out_seq <= '0;
            r_last_out_ts  <= '0;
        end else if (w_adv) begin
            r_started <= 1'b1;
            if (!r_started || w_fresh) begin
                r_cur_source <= r_in_source;
                r_seq_off    <= n_out_seq - r_in_seq;
                r_ts_off     <= n_out_ts - r_in_ts;
            end
            if (w_upd_out) begin
                r_last_out_seq <= n_out_seq;
                r_last_out_ts  <= n_out_ts;
            end
            if (w_upd_in) begin
                r_last_in_seq <= r_in_seq;
                r_last_in_ts  <= r_in_ts;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_out_seq     <= n_out_seq;
            r_out_ts      <= n_out_ts;
            r_out_rebased <= w_fresh;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.seq_out = r_out_seq;
    assign o_out.ts_out  = r_out_ts;
    assign o_out.rebased = r_out_rebased;

    // Checks on the pipeline and series logic.
    `RHR_ASSERT_NOW(a_ready_when_out_free, !r_out_valid, i_in.ready,
        "input not ready although the output register is free")
    `RHR_ASSERT_NEXT(a_first_not_rebased, w_adv && !r_started, !r_out_rebased,
        "first header after reset flagged as rebased")
    `RHR_ASSERT_NEXT(a_fresh_continues, w_adv && w_fresh,
        r_out_seq == $past(w_seq_next) && r_out_ts == $past(w_ts_handover),
        "new series does not continue after the highest sequence sent")
    `RHR_ASSERT_NEXT(a_mark_source, w_adv,
        r_last_out_seq == $past(r_last_out_seq) || r_last_out_seq == r_out_seq,
        "output high-water mark changed to a value not sent")

endmodule
